/* src/cftt_pkg.sv */
// shared types and constants for the client failure throttle table
`timescale 1ns / 1ps
`default_nettype none
package cftt_pkg;

    // action codes on the input stream
    localparam logic [1:0] ACT_CHECK = 2'd0;
    localparam logic [1:0] ACT_FAIL  = 2'd1;
    localparam logic [1:0] ACT_SUCC  = 2'd2;

    // result status codes
    localparam logic [2:0] STAT_ALLOW   = 3'd0;
    localparam logic [2:0] STAT_DENIED  = 3'd1;
    localparam logic [2:0] STAT_BANNED  = 3'd2;
    localparam logic [2:0] STAT_FULL    = 3'd3;
    localparam logic [2:0] STAT_COUNTED = 3'd4;

    // register indexes on the config port
    localparam logic [1:0] REG_ENABLE = 2'd0;
    localparam logic [1:0] REG_LIMIT  = 2'd1;
    localparam logic [1:0] REG_WINDOW = 2'd2;
    localparam logic [1:0] REG_BAN    = 2'd3;

    // entries are only stale after at least this many seconds
    localparam logic [31:0] STALE_FLOOR = 32'd3600;

    typedef enum logic [1:0] {
        OP_NOP,
        OP_CHECK,
        OP_FAIL,
        OP_SUCC
    } op_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_FIND,
        BK_EVA,
        BK_SHIFT,
        BK_RANK,
        BK_FREE,
        BK_UPD1,
        BK_UPD2,
        BK_DONE
    } back_state_t;

    typedef enum logic [1:0] {
        RM_DELETE,
        RM_TOHEAD,
        RM_ALLOC,
        RM_EVICT
    } rank_mode_t;

    typedef struct packed {
        op_t         op;
        logic [31:0] key;
        logic [31:0] now;
    } item_t;

    typedef struct packed {
        logic        enable;
        logic [15:0] limit;
        logic [31:0] window;
        logic [31:0] ban;
    } cfg_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } queue_out_t;

endpackage
`default_nettype wire

/* src/cftt_front.sv */
// input side: accepts beats, classifies the action, holds a two-entry queue
`timescale 1ns / 1ps
`default_nettype none
module cftt_front
    import cftt_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        enable,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,  // client_key, current_time
    input  wire logic [1:0]  s_tuser,  // action
    output queue_out_t       q_out,
    input  wire logic        q_pop
);

    item_t      q_mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;
    logic       push;
    item_t      new_item;

    always_comb
    begin
        new_item.key = s_tdata[31:0];
        new_item.now = s_tdata[63:32];
        if (!enable)
        begin
            new_item.op = OP_NOP;
        end
        else
        begin
            case (s_tuser)
                ACT_CHECK: new_item.op = OP_CHECK;
                ACT_FAIL:  new_item.op = OP_FAIL;
                ACT_SUCC:  new_item.op = OP_SUCC;
                default:   new_item.op = OP_NOP;
            endcase
        end
    end

    assign s_tready    = (fill_reg != 2'd2);
    assign push        = s_tvalid && s_tready;
    assign q_out.valid = (fill_reg != 2'd0);
    assign q_out.item  = q_mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= new_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !q_pop)
            begin
                fill_reg <= fill_reg + 2'd1;
            end
            else if (!push && q_pop)
            begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

endmodule
`default_nettype wire

/* src/cftt_back.sv */
// table engine: scans, lru rank passes, eviction and entry update
`timescale 1ns / 1ps
`default_nettype none
module cftt_back
    import cftt_pkg::*;
#(
    parameter int ENTRIES    = 64,
    parameter int FIRST_SCAN = 8
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cfg_t        cfg,
    input  wire queue_out_t  q_in,
    output logic             q_pop,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [2:0]       m_status,
    output logic [15:0]      m_count,
    output logic [32:0]      m_remain
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 2);
    localparam int NV_W  = $clog2(ENTRIES + 1);
    localparam int LIM_W = $clog2(2 * ENTRIES + FIRST_SCAN + 1);
    localparam logic [CNT_W-1:0] K_LAST1 = CNT_W'(ENTRIES);
    localparam logic [CNT_W-1:0] K_LAST2 = CNT_W'(ENTRIES + 1);
    localparam logic [LIM_W-1:0] LIM_FIRST = LIM_W'(FIRST_SCAN);
    localparam logic [LIM_W-1:0] LIM_ALL   = LIM_W'(ENTRIES);

    // table memories
    logic [31:0]      key_mem   [ENTRIES];
    logic [31:0]      ws_mem    [ENTRIES];
    logic [32:0]      bu_mem    [ENTRIES];
    logic [15:0]      cnt_mem   [ENTRIES];
    logic [IDX_W-1:0] rank_mem  [ENTRIES];
    logic [NV_W-1:0]  shift_mem [ENTRIES];

    logic [31:0]      rd_key;
    logic [31:0]      rd_ws;
    logic [32:0]      rd_bu;
    logic [15:0]      rd_cnt;
    logic [IDX_W-1:0] rd_rank;
    logic [NV_W-1:0]  rd_shift;
    logic [IDX_W-1:0] rd_addr;

    back_state_t      state_reg, state_next;
    rank_mode_t       mode_reg, mode_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic             round2_reg, round2_next;
    item_t            item_reg, item_next;
    logic [31:0]      stale_reg, stale_next;
    logic             found_reg, found_next;
    logic [IDX_W-1:0] slot_reg, slot_next;
    logic [IDX_W-1:0] s_rank_reg, s_rank_next;
    logic [31:0]      s_ws_reg, s_ws_next;
    logic [32:0]      s_bu_reg, s_bu_next;
    logic [15:0]      s_cnt_reg, s_cnt_next;
    logic [NV_W-1:0]  n_reg, n_next;
    logic [NV_W-1:0]  acc_reg, acc_next;
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [ENTRIES-1:0] drop_slot_reg, drop_slot_next;
    logic [ENTRIES-1:0] drop_rank_reg, drop_rank_next;
    logic [IDX_W-1:0] p2_rank_reg;
    logic [2:0]       res_status_reg, res_status_next;
    logic [15:0]      res_count_reg, res_count_next;
    logic [32:0]      res_remain_reg, res_remain_next;
    logic             m_valid_reg, m_valid_next;
    logic [2:0]       m_status_reg, m_status_next;
    logic [15:0]      m_count_reg, m_count_next;
    logic [32:0]      m_remain_reg, m_remain_next;

    logic             upd_we;
    logic [31:0]      upd_ws;
    logic [32:0]      upd_bu;
    logic [15:0]      upd_cnt;
    logic             rank_we;
    logic [IDX_W-1:0] rank_waddr;
    logic [IDX_W-1:0] rank_wdata;
    logic             shift_we;

    logic [CNT_W-1:0] km1, km2;
    logic [IDX_W-1:0] idx1, idx2;
    logic             s1_live, s2_live;
    logic [32:0]      now33;
    logic [LIM_W-1:0] lim;
    logic [NV_W-1:0]  rank2_ext;
    logic [15:0]      cnt_inc;

    assign km1     = k_reg - CNT_W'(1);
    assign km2     = k_reg - CNT_W'(2);
    assign idx1    = km1[IDX_W-1:0];
    assign idx2    = km2[IDX_W-1:0];
    assign s1_live = (k_reg != '0) && (k_reg <= K_LAST1);
    assign s2_live = (k_reg >= CNT_W'(2)) && (k_reg <= K_LAST2);
    assign now33   = {1'b0, item_reg.now};
    assign lim     = round2_reg ? LIM_ALL : LIM_FIRST;
    assign rank2_ext = NV_W'(p2_rank_reg);
    assign cnt_inc = (s_cnt_reg == 16'hFFFF) ? s_cnt_reg : s_cnt_reg + 16'd1;
    assign rd_addr = (k_reg < K_LAST1) ? k_reg[IDX_W-1:0] : '0;

    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        k_next          = k_reg;
        round2_next     = round2_reg;
        item_next       = item_reg;
        stale_next      = stale_reg;
        found_next      = found_reg;
        slot_next       = slot_reg;
        s_rank_next     = s_rank_reg;
        s_ws_next       = s_ws_reg;
        s_bu_next       = s_bu_reg;
        s_cnt_next      = s_cnt_reg;
        n_next          = n_reg;
        acc_next        = acc_reg;
        valid_next      = valid_reg;
        drop_slot_next  = drop_slot_reg;
        drop_rank_next  = drop_rank_reg;
        res_status_next = res_status_reg;
        res_count_next  = res_count_reg;
        res_remain_next = res_remain_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_status_next   = m_status_reg;
        m_count_next    = m_count_reg;
        m_remain_next   = m_remain_reg;
        q_pop           = 1'b0;
        upd_we          = 1'b0;
        upd_ws          = s_ws_reg;
        upd_bu          = s_bu_reg;
        upd_cnt         = cnt_inc;
        rank_we         = 1'b0;
        rank_waddr      = idx2;
        rank_wdata      = p2_rank_reg;
        shift_we        = 1'b0;

        case (state_reg)
            BK_IDLE:
            begin
                if (q_in.valid)
                begin
                    q_pop           = 1'b1;
                    item_next       = q_in.item;
                    stale_next      = (cfg.window > STALE_FLOOR) ? cfg.window : STALE_FLOOR;
                    res_status_next = STAT_ALLOW;
                    res_count_next  = '0;
                    res_remain_next = '0;
                    found_next      = 1'b0;
                    n_next          = '0;
                    k_next          = '0;
                    round2_next     = 1'b0;
                    state_next      = (q_in.item.op == OP_NOP) ? BK_DONE : BK_FIND;
                end
            end

            BK_FIND:
            begin
                k_next = k_reg + CNT_W'(1);
                if (s1_live && valid_reg[idx1])
                begin
                    n_next = n_reg + NV_W'(1);
                    if (rd_key == item_reg.key)
                    begin
                        found_next  = 1'b1;
                        slot_next   = idx1;
                        s_rank_next = rd_rank;
                        s_ws_next   = rd_ws;
                        s_bu_next   = rd_bu;
                        s_cnt_next  = rd_cnt;
                    end
                end
                if (k_reg == K_LAST2)
                begin
                    k_next = '0;
                    case (item_reg.op)
                        OP_CHECK:
                        begin
                            if (found_reg && (s_bu_reg > now33))
                            begin
                                res_status_next = STAT_DENIED;
                                res_remain_next = s_bu_reg - now33;
                            end
                            state_next = BK_DONE;
                        end
                        OP_SUCC:
                        begin
                            if (found_reg)
                            begin
                                valid_next[slot_reg] = 1'b0;
                                mode_next            = RM_DELETE;
                                state_next           = BK_RANK;
                            end
                            else
                            begin
                                state_next = BK_DONE;
                            end
                        end
                        OP_FAIL:
                        begin
                            if (found_reg)
                            begin
                                mode_next  = RM_TOHEAD;
                                state_next = BK_RANK;
                            end
                            else
                            begin
                                drop_slot_next = '0;
                                drop_rank_next = '0;
                                state_next     = BK_EVA;
                            end
                        end
                        default:
                        begin
                            state_next = BK_DONE;
                        end
                    endcase
                end
            end

            // mark stale entries among the oldest ones (among all entries in the second round)
            BK_EVA:
            begin
                k_next = k_reg + CNT_W'(1);
                if (s1_live && valid_reg[idx1] &&
                    ((LIM_W'(rd_rank) + lim) >= LIM_W'(n_reg)) &&
                    (rd_bu <= now33) &&
                    (({1'b0, rd_ws} + {1'b0, stale_reg}) <= now33))
                begin
                    drop_slot_next[idx1]    = 1'b1;
                    drop_rank_next[rd_rank] = 1'b1;
                end
                if (k_reg == K_LAST2)
                begin
                    k_next     = '0;
                    acc_next   = '0;
                    state_next = BK_SHIFT;
                end
            end

            // per rank: how many dropped entries sit below it
            BK_SHIFT:
            begin
                k_next = k_reg + CNT_W'(1);
                if (k_reg < K_LAST1)
                begin
                    shift_we = 1'b1;
                    acc_next = acc_reg + NV_W'(drop_rank_reg[k_reg[IDX_W-1:0]]);
                end
                else
                begin
                    k_next     = '0;
                    mode_next  = RM_EVICT;
                    state_next = BK_RANK;
                end
            end

            BK_RANK:
            begin
                k_next = k_reg + CNT_W'(1);
                if (s2_live && valid_reg[idx2] &&
                    !((mode_reg == RM_EVICT) && drop_slot_reg[idx2]))
                begin
                    rank_we = 1'b1;
                    case (mode_reg)
                        RM_DELETE:
                        begin
                            if (p2_rank_reg > s_rank_reg)
                            begin
                                rank_wdata = p2_rank_reg - IDX_W'(1);
                            end
                        end
                        RM_TOHEAD:
                        begin
                            if (idx2 == slot_reg)
                            begin
                                rank_wdata = '0;
                            end
                            else if (p2_rank_reg < s_rank_reg)
                            begin
                                rank_wdata = p2_rank_reg + IDX_W'(1);
                            end
                        end
                        RM_ALLOC:
                        begin
                            rank_wdata = p2_rank_reg + IDX_W'(1);
                        end
                        default:
                        begin
                            rank_wdata = IDX_W'(rank2_ext - rd_shift);
                        end
                    endcase
                end
                if (k_reg == K_LAST2)
                begin
                    k_next = '0;
                    case (mode_reg)
                        RM_DELETE:
                        begin
                            state_next = BK_DONE;
                        end
                        RM_TOHEAD:
                        begin
                            state_next = BK_UPD1;
                        end
                        RM_ALLOC:
                        begin
                            valid_next[slot_reg] = 1'b1;
                            s_ws_next            = item_reg.now;
                            s_bu_next            = '0;
                            s_cnt_next           = '0;
                            state_next           = BK_UPD1;
                        end
                        default:
                        begin
                            valid_next = valid_reg & ~drop_slot_reg;
                            n_next     = '0;
                            found_next = 1'b0;
                            state_next = BK_FREE;
                        end
                    endcase
                end
            end

            // lowest free slot and a fresh count of valid entries
            BK_FREE:
            begin
                k_next = k_reg + CNT_W'(1);
                if (s1_live)
                begin
                    if (valid_reg[idx1])
                    begin
                        n_next = n_reg + NV_W'(1);
                    end
                    else if (!found_reg)
                    begin
                        found_next = 1'b1;
                        slot_next  = idx1;
                    end
                end
                if (k_reg == K_LAST2)
                begin
                    k_next = '0;
                    if (found_reg)
                    begin
                        mode_next  = RM_ALLOC;
                        state_next = BK_RANK;
                    end
                    else if (!round2_reg)
                    begin
                        round2_next    = 1'b1;
                        drop_slot_next = '0;
                        drop_rank_next = '0;
                        state_next     = BK_EVA;
                    end
                    else
                    begin
                        res_status_next = STAT_FULL;
                        state_next      = BK_DONE;
                    end
                end
            end

            // window restart
            BK_UPD1:
            begin
                if (({1'b0, s_ws_reg} + {1'b0, cfg.window}) <= now33)
                begin
                    s_ws_next  = item_reg.now;
                    s_cnt_next = '0;
                end
                state_next = BK_UPD2;
            end

            // count, ban and write back
            BK_UPD2:
            begin
                upd_we         = 1'b1;
                rank_we        = 1'b1;
                rank_waddr     = slot_reg;
                rank_wdata     = '0;
                res_count_next = cnt_inc;
                if (cnt_inc >= cfg.limit)
                begin
                    upd_bu          = now33 + {1'b0, cfg.ban};
                    res_status_next = STAT_BANNED;
                end
                else
                begin
                    res_status_next = STAT_COUNTED;
                end
                state_next = BK_DONE;
            end

            BK_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_count_next  = res_count_reg;
                    m_remain_next = res_remain_reg;
                    state_next    = BK_IDLE;
                end
            end

            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (upd_we)
        begin
            key_mem[slot_reg] <= item_reg.key;
            ws_mem[slot_reg]  <= upd_ws;
            bu_mem[slot_reg]  <= upd_bu;
            cnt_mem[slot_reg] <= upd_cnt;
        end
        if (rank_we)
        begin
            rank_mem[rank_waddr] <= rank_wdata;
        end
        if (shift_we)
        begin
            shift_mem[k_reg[IDX_W-1:0]] <= acc_reg;
        end
        rd_key   <= key_mem[rd_addr];
        rd_ws    <= ws_mem[rd_addr];
        rd_bu    <= bu_mem[rd_addr];
        rd_cnt   <= cnt_mem[rd_addr];
        rd_rank  <= rank_mem[rd_addr];
        rd_shift <= shift_mem[rd_rank];
    end

    always_ff @(posedge clk)
    begin
        item_reg       <= item_next;
        stale_reg      <= stale_next;
        slot_reg       <= slot_next;
        s_rank_reg     <= s_rank_next;
        s_ws_reg       <= s_ws_next;
        s_bu_reg       <= s_bu_next;
        s_cnt_reg      <= s_cnt_next;
        acc_reg        <= acc_next;
        p2_rank_reg    <= rd_rank;
        res_status_reg <= res_status_next;
        res_count_reg  <= res_count_next;
        res_remain_reg <= res_remain_next;
        m_status_reg   <= m_status_next;
        m_count_reg    <= m_count_next;
        m_remain_reg   <= m_remain_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            mode_reg      <= RM_DELETE;
            k_reg         <= '0;
            round2_reg    <= 1'b0;
            found_reg     <= 1'b0;
            n_reg         <= '0;
            valid_reg     <= '0;
            drop_slot_reg <= '0;
            drop_rank_reg <= '0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            k_reg         <= k_next;
            round2_reg    <= round2_next;
            found_reg     <= found_next;
            n_reg         <= n_next;
            valid_reg     <= valid_next;
            drop_slot_reg <= drop_slot_next;
            drop_rank_reg <= drop_rank_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_count  = m_count_reg;
    assign m_remain = m_remain_reg;

endmodule
`default_nettype wire

/* src/client_failure_throttle_table.sv */
// top level of the client failure throttle table
//
//  channel   | direction | handshake                     | beat contents
//  ----------+-----------+-------------------------------+----------------------------------
//  config    | in        | psel & penable & pwrite       | 4 registers at 4*i, 32-bit data
//  s_        | in        | s_tvalid & s_tready           | tuser action, tdata key and time
//  m_        | out       | m_tvalid & m_tready           | tuser status, tdata count, remain
//
// one result beat for each input beat, in order
// a check or an unknown success takes one key scan; removing a known client adds
// a rank pass, counting a failure of a known client a rank pass and the update,
// and a new client may need both stale sweeps; each sweep reads one table entry
// per cycle from the memories
// reset clears the valid flags at once, no clearing pass; table contents stay
// undefined until written
// a two-beat input queue keeps taking beats while the engine works, and the
// output register holds a result while the sink stalls
`timescale 1ns / 1ps
`default_nettype none
module client_failure_throttle_table
    import cftt_pkg::*;
#(
    parameter int ENTRIES    = 64,
    parameter int FIRST_SCAN = 8
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // config port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // request stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // client_key, current_time
    input  wire logic [1:0]  s_tuser,   // action
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [55:0] m_tdata,   // failure_count, ban_remaining, zero fill
    output logic      [2:0]  m_tuser    // status
);

    logic        enable_reg;
    logic [15:0] limit_reg;
    logic [31:0] window_reg;
    logic [31:0] ban_reg;
    logic        cfg_write;
    cfg_t        cfg;
    queue_out_t  q_out;
    logic        q_pop;
    logic [15:0] res_count;
    logic [32:0] res_remain;

    assign pready    = 1'b1;
    // register written in the access phase
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            limit_reg  <= 16'd5;
            window_reg <= 32'd300;
            ban_reg    <= 32'd600;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_ENABLE: enable_reg <= pwdata[0];
                REG_LIMIT:  limit_reg  <= pwdata[15:0];
                REG_WINDOW: window_reg <= pwdata;
                REG_BAN:    ban_reg    <= pwdata;
                default:    enable_reg <= enable_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_ENABLE: prdata = {31'd0, enable_reg};
            REG_LIMIT:  prdata = {16'd0, limit_reg};
            REG_WINDOW: prdata = window_reg;
            REG_BAN:    prdata = ban_reg;
            default:    prdata = '0;
        endcase
    end

    assign cfg.enable = enable_reg;
    assign cfg.limit  = limit_reg;
    assign cfg.window = window_reg;
    assign cfg.ban    = ban_reg;

    // front: accept and classify
    cftt_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .enable   (enable_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_out    (q_out),
        .q_pop    (q_pop)
    );

    // back: table engine and result register
    cftt_back #(
        .ENTRIES    (ENTRIES),
        .FIRST_SCAN (FIRST_SCAN)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .q_in     (q_out),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_status (m_tuser),
        .m_count  (res_count),
        .m_remain (res_remain)
    );

    assign m_tdata = {7'd0, res_remain, res_count};

endmodule
`default_nettype wire

/* src/cftt_checker.sv */
// port-level checks on the result stream, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module cftt_checker
    import cftt_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [55:0] m_tdata,
    input wire logic [2:0]  m_tuser
);

    // stalled result beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result beat changed");

    // a denied check carries time left and no count
    a_denied: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == STAT_DENIED) |->
            (m_tdata[15:0] == 16'd0) && (m_tdata[48:16] != 33'd0))
        else $error("denied beat with bad fields");

    // a counted failure carries a count and no time left
    a_counted: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && ((m_tuser == STAT_BANNED) || (m_tuser == STAT_COUNTED)) |->
            (m_tdata[15:0] != 16'd0) && (m_tdata[48:16] == 33'd0))
        else $error("counted beat with bad fields");

    // allowed or skipped beats carry nothing
    a_plain: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && ((m_tuser == STAT_ALLOW) || (m_tuser == STAT_FULL)) |->
            (m_tdata == 56'd0))
        else $error("plain beat with nonzero fields");

endmodule

bind client_failure_throttle_table cftt_checker u_cftt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire

/* tb/sv/tb_client_failure_throttle_table.sv */
// self-checking testbench for the client failure throttle table
`timescale 1ns / 1ps
`default_nettype none
module tb_client_failure_throttle_table;
    import cftt_pkg::*;

    localparam int NSLOT = 64;
    localparam int OLDEST_SCAN = 8;
    localparam int STALL_LIMIT = 200000;

    // predictor of the throttle table plus a queue of expected result beats
    class throttle_scoreboard;
        bit        enable;
        bit [15:0] limit;
        bit [31:0] window;
        bit [31:0] ban;
        bit        used [NSLOT];
        bit [31:0] key_of [NSLOT];
        bit [31:0] win_start [NSLOT];
        bit [32:0] ban_until [NSLOT];
        bit [15:0] fails [NSLOT];
        int        age [NSLOT];
        bit [2:0]  want_status [$];
        bit [15:0] want_count [$];
        bit [32:0] want_remain [$];
        int        errors;

        function void clear();
            enable = 0; limit = 5; window = 300; ban = 600;
            foreach (used[i]) used[i] = 0;
            errors = 0;
        endfunction

        function void set_reg(logic [1:0] idx, bit [31:0] v);
            case (idx)
                REG_ENABLE: enable = v[0];
                REG_LIMIT:  limit = v[15:0];
                REG_WINDOW: window = v;
                default:    ban = v;
            endcase
        endfunction

        function int lookup(bit [31:0] k);
            for (int i = 0; i < NSLOT; i++)
                if (used[i] && key_of[i] == k) return i;
            return -1;
        endfunction

        function int first_free();
            for (int i = 0; i < NSLOT; i++)
                if (!used[i]) return i;
            return -1;
        endfunction

        // free stale entries among the span oldest
        function void sweep(bit [32:0] now, int span);
            bit drop [NSLOT];
            bit [32:0] horizon;
            int n;
            int lower;
            horizon = (window > STALE_FLOOR) ? window : STALE_FLOOR;
            n = 0;
            foreach (used[i]) if (used[i]) n++;
            foreach (drop[i])
                drop[i] = used[i] && age[i] >= n - span && ban_until[i] <= now
                          && ({1'b0, win_start[i]} + horizon) <= now;
            foreach (used[i])
            begin
                if (used[i] && !drop[i])
                begin
                    lower = 0;
                    foreach (drop[j]) if (drop[j] && age[j] < age[i]) lower++;
                    age[i] -= lower;
                end
            end
            foreach (drop[i]) if (drop[i]) used[i] = 0;
        endfunction

        function void note_request(logic [1:0] act, bit [31:0] k, bit [31:0] t);
            bit [2:0]  st;
            bit [15:0] cnt;
            bit [32:0] rem;
            bit [32:0] now;
            int s;
            int r;
            st = STAT_ALLOW; cnt = 0; rem = 0; now = {1'b0, t};
            if (enable && act == ACT_CHECK)
            begin
                s = lookup(k);
                if (s >= 0 && ban_until[s] > now)
                begin
                    st = STAT_DENIED;
                    rem = ban_until[s] - now;
                end
            end
            else if (enable && act == ACT_SUCC)
            begin
                s = lookup(k);
                if (s >= 0)
                begin
                    used[s] = 0;
                    foreach (used[i]) if (used[i] && age[i] > age[s]) age[i]--;
                end
            end
            else if (enable && act == ACT_FAIL)
            begin
                s = lookup(k);
                if (s < 0)
                begin
                    sweep(now, OLDEST_SCAN);
                    s = first_free();
                    if (s < 0)
                    begin
                        sweep(now, NSLOT);
                        s = first_free();
                    end
                    if (s >= 0)
                    begin
                        foreach (used[i]) if (used[i]) age[i]++;
                        used[s] = 1; key_of[s] = k; win_start[s] = t;
                        ban_until[s] = 0; fails[s] = 0; age[s] = 0;
                    end
                end
                else
                begin
                    r = age[s];
                    foreach (used[i]) if (i != s && used[i] && age[i] < r) age[i]++;
                    age[s] = 0;
                end
                if (s < 0)
                    st = STAT_FULL;
                else
                begin
                    if ({1'b0, win_start[s]} + {1'b0, window} <= now)
                    begin
                        win_start[s] = t;
                        fails[s] = 0;
                    end
                    if (fails[s] != 16'hFFFF) fails[s]++;
                    cnt = fails[s];
                    if (cnt >= limit)
                    begin
                        ban_until[s] = now + ban;
                        st = STAT_BANNED;
                    end
                    else
                        st = STAT_COUNTED;
                end
            end
            want_status.push_back(st);
            want_count.push_back(cnt);
            want_remain.push_back(rem);
        endfunction

        function void check_result(bit [2:0] st, bit [15:0] cnt, bit [32:0] rem);
            if (want_status.size() == 0)
            begin
                $display("%0t: unexpected result beat status %0d", $time, st);
                errors++;
                return;
            end
            if (want_status[0] != st)
            begin
                $display("%0t: status expected %0d actual %0d", $time, want_status[0], st);
                errors++;
            end
            if (want_count[0] != cnt)
            begin
                $display("%0t: count expected %0d actual %0d", $time, want_count[0], cnt);
                errors++;
            end
            if (want_remain[0] != rem)
            begin
                $display("%0t: remain expected %0d actual %0d", $time, want_remain[0], rem);
                errors++;
            end
            void'(want_status.pop_front());
            void'(want_count.pop_front());
            void'(want_remain.pop_front());
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // client_key, current_time
    logic [1:0]  s_tuser;   // action
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;   // failure_count, ban_remaining, zero fill
    logic [2:0]  m_tuser;   // status

    throttle_scoreboard sb;
    int  idle_cycles;
    bit  sink_gaps;       // random stalls on the result side
    bit  sink_hold;       // long hold-off request
    bit  src_gaps;
    bit [31:0] clock_now; // mostly increasing time fed into requests, sometimes stepping back
    bit [31:0] keys [16]; // small key pool so entries get revisited

    client_failure_throttle_table dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    // result side: check accepted beats, stall in bursts
    initial
    begin
        int gap;
        m_tready = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                sb.check_result(m_tuser, m_tdata[15:0], m_tdata[48:16]);
            if (sink_hold)
                m_tready <= 0;
            else if (sink_gaps && gap == 0 && $urandom_range(0, 5) == 0)
            begin
                gap = $urandom_range(1, 10);
                m_tready <= 0;
            end
            else if (gap > 0)
            begin
                gap--;
                m_tready <= (gap == 0);
            end
            else
                m_tready <= 1;
        end
    end

    // watchdog: cycles with no beat accepted on either stream and no config access
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles > STALL_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [1:0] idx, bit [31:0] v);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= v;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        sb.set_reg(idx, v);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    // one request beat; random gap ahead of it when enabled
    task automatic send(logic [1:0] act, bit [31:0] k, bit [31:0] t);
        int gap;
        if (src_gaps && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 10);
            s_tvalid <= 0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1;
        s_tuser <= act;
        s_tdata <= {t, k};
        do @(posedge clk); while (!s_tready);
        sb.note_request(act, k, t);
    endtask

    task automatic end_of_burst();
        s_tvalid <= 0;
    endtask

    // wait until every result is back, plus engine drain time
    task automatic drain();
        end_of_burst();
        while (sb.want_status.size() != 0) @(posedge clk);
        repeat (700) @(posedge clk);
    endtask

    function automatic bit [31:0] step_time();
        // mostly small advances, sometimes large jumps, rarely backwards
        case ($urandom_range(0, 19))
            0:       clock_now = clock_now + $urandom_range(3000, 9000);
            1:       clock_now = clock_now - $urandom_range(0, 50);
            default: clock_now = clock_now + $urandom_range(0, 40);
        endcase
        return clock_now;
    endfunction

    task automatic random_phase(int count, int span);
        bit [31:0] k;
        int pick;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            k = (pick < 85) ? keys[$urandom_range(0, span - 1)] : $urandom;
            pick = $urandom_range(0, 99);
            if (pick < 55)
                send(ACT_FAIL, k, step_time());
            else if (pick < 85)
                send(ACT_CHECK, k, step_time());
            else if (pick < 97)
                send(ACT_SUCC, k, step_time());
            else
                send(2'd3, k, step_time());
        end
    endtask

    initial
    begin
        sb = new();
        sb.clear();
        rst_n = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        s_tvalid = 0; s_tdata = 0; s_tuser = 0;
        sink_gaps = 0; sink_hold = 0; src_gaps = 0;
        clock_now = 0;
        foreach (keys[i]) keys[i] = $urandom;
        keys[0] = 0;
        keys[1] = 32'hFFFF_FFFF;
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // disabled: everything answers allowed
        send(ACT_FAIL, keys[2], 10);
        send(ACT_CHECK, keys[2], 10);
        send(2'd3, keys[2], 10);
        drain();

        // directed: count up to a ban, denied check, success clears
        write_reg(REG_ENABLE, 1);
        for (int i = 0; i < 5; i++) send(ACT_FAIL, keys[0], 100 + i);
        send(ACT_CHECK, keys[0], 200);
        send(ACT_CHECK, keys[0], 704);
        send(ACT_SUCC, keys[0], 705);
        send(ACT_CHECK, keys[0], 706);
        send(ACT_FAIL, keys[1], 32'hFFFF_FFF0);
        send(ACT_CHECK, keys[1], 32'hFFFF_FFF0);
        send(ACT_SUCC, keys[3], 32'hFFFF_FFF0);
        send(2'd3, keys[1], 32'hFFFF_FFFF);
        drain();

        // zero limit, maximal ban: every failure bans, remain past 32 bits
        write_reg(REG_LIMIT, 0);
        write_reg(REG_BAN, 32'hFFFF_FFFF);
        write_reg(REG_WINDOW, 32'hFFFF_FFFF);
        send(ACT_FAIL, keys[4], 32'hFFFF_FF00);
        send(ACT_CHECK, keys[4], 32'hFFFF_FF01);
        send(ACT_CHECK, keys[4], 0);
        drain();

        // fill the table with fresh keys, then hit the full path
        write_reg(REG_LIMIT, 16'hFFFF);
        write_reg(REG_WINDOW, 0);
        write_reg(REG_BAN, 0);
        src_gaps = 1; sink_gaps = 1;
        for (int i = 0; i < NSLOT + 4; i++) send(ACT_FAIL, 32'h1000 + i, 50000);
        // window 0 restarts each time; stale floor still frees after 3600
        send(ACT_FAIL, 32'h5555, 53600);
        drain();

        // window never ends, limit max: the count keeps climbing
        write_reg(REG_WINDOW, 32'hFFFF_FFFF);
        for (int i = 0; i < 40; i++)
        begin
            if (i == 10) src_gaps = 0;
            if (i == 20) sink_gaps = 0;
            send(ACT_FAIL, 32'hABCD, 60000);
        end
        drain();
        write_reg(REG_ENABLE, 0);
        send(ACT_FAIL, 32'hABCD, 60000);
        drain();
        write_reg(REG_ENABLE, 1);
        send(ACT_FAIL, 32'hABCD, 60001);
        drain();

        // random phases over several settings
        src_gaps = 1; sink_gaps = 1;
        write_reg(REG_LIMIT, 3); write_reg(REG_WINDOW, 300); write_reg(REG_BAN, 600);
        clock_now = 100000;
        random_phase(500, 16);

        // long receiver hold-off while requests keep coming
        fork
            begin
                sink_hold = 1;
                repeat (400) @(posedge clk);
                sink_hold = 0;
            end
            random_phase(60, 16);
        join
        drain();

        write_reg(REG_LIMIT, 5); write_reg(REG_WINDOW, 4000); write_reg(REG_BAN, 50);
        for (int i = 0; i < 16; i++) keys[i] = $urandom;
        random_phase(500, 16);
        drain();

        write_reg(REG_LIMIT, 2); write_reg(REG_WINDOW, 10); write_reg(REG_BAN, 1000);
        random_phase(400, 16);
        drain();

        // quiet tail: no idling on either side
        src_gaps = 0; sink_gaps = 0;
        write_reg(REG_LIMIT, 1);
        random_phase(300, 16);
        drain();

        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
`default_nettype wire

/* files.f */
src/cftt_pkg.sv
src/cftt_front.sv
src/cftt_back.sv
src/client_failure_throttle_table.sv
src/cftt_checker.sv
tb/sv/tb_client_failure_throttle_table.sv
